// ----- hw/rtl/ppc_pkg.sv -----
// Shared types, constants and coefficient lookup for the pixel polynomial correction block.
`default_nettype none

package ppc_pkg;

    localparam int PIX_W          = 32;
    localparam int COEF_W         = 32;
    localparam int ACC_W          = 48;
    localparam int CFG_W          = 64;
    localparam int DEG_W          = 4;
    localparam int CFG_IDX_W      = 3;
    localparam int NUM_PAIRS      = 5;
    localparam int MAX_DEGREE_DEF = 9;
    localparam int PROD_SHIFT     = 16;
    localparam int OUT_SHIFT      = 8;

    localparam logic [DEG_W-1:0] DEGREE_RESET = DEG_W'(1);
    localparam logic [CFG_W-1:0] PAIR01_RESET = CFG_W'(1) << 56;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEGREE   = 3'd0,
        REG_PAIR_0_1 = 3'd1,
        REG_PAIR_2_3 = 3'd2,
        REG_PAIR_4_5 = 3'd3,
        REG_PAIR_6_7 = 3'd4,
        REG_PAIR_8_9 = 3'd5
    } cfg_reg_t;

    typedef logic [NUM_PAIRS-1:0][CFG_W-1:0] coef_bank_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] acc;
        logic                    x_neg;
        logic [PIX_W-1:0]        x_mag;
        logic                    sat;
        logic                    last;
    } horner_beat_t;

    typedef struct packed {
        logic signed [PIX_W-1:0] pixel;
        logic                    sat;
        logic                    last;
    } result_beat_t;

    // Coefficient k: even k in the low half of its pair, odd k in the high half.
    function automatic logic signed [COEF_W-1:0] coef_at(
        input coef_bank_t       bank,
        input logic [DEG_W-1:0] k
    );
        logic [CFG_W-1:0] pair;
        case (k[DEG_W-1:1])
            3'd0:    pair = bank[0];
            3'd1:    pair = bank[1];
            3'd2:    pair = bank[2];
            3'd3:    pair = bank[3];
            3'd4:    pair = bank[4];
            3'd5:    pair = bank[0];
            3'd6:    pair = bank[1];
            default: pair = bank[2];
        endcase
        return k[0] ? $signed(pair[CFG_W-1:COEF_W]) : $signed(pair[COEF_W-1:0]);
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ppc_horner_step.sv -----
// When active, one Horner step: multiply by sample, round, saturate, add coef, saturate.
`default_nettype none

module ppc_horner_step
    import ppc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     active,
    input  logic signed [COEF_W-1:0] coef,
    input  logic                     in_valid,
    input  horner_beat_t             in_beat,
    output logic                     out_valid,
    output horner_beat_t             out_beat
);

    localparam int SPLIT     = 32;
    localparam int HI_W      = ACC_W - SPLIT;
    localparam int PROD_HI_W = HI_W + PIX_W;
    localparam int PROD_LO_W = SPLIT + PIX_W;
    localparam int SUM_W     = PROD_LO_W + 1;
    localparam int SUMD_W    = ACC_W + 1;

    localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (PROD_SHIFT - 1);
    localparam logic [SUM_W-1:0] POS_LIMIT  = (SUM_W'(1) << (ACC_W - 1)) - SUM_W'(1);
    localparam logic [SUM_W-1:0] NEG_LIMIT  = SUM_W'(1) << (ACC_W - 1);

    // stage A: magnitude of the accumulator
    logic                 a_valid_reg;
    horner_beat_t         a_beat_reg;
    logic [ACC_W-1:0]     a_mag_reg;
    logic [ACC_W-1:0]     a_mag_next;
    logic                 a_neg_reg;
    logic                 a_neg_next;

    // stage B: partial products
    logic                 b_valid_reg;
    horner_beat_t         b_beat_reg;
    logic                 b_neg_reg;
    logic [PROD_HI_W-1:0] b_hi_reg;
    logic [PROD_HI_W-1:0] b_hi_next;
    logic [PROD_LO_W-1:0] b_lo_reg;
    logic [PROD_LO_W-1:0] b_lo_next;

    // stage C: rounded, saturated product
    logic                    c_valid_reg;
    horner_beat_t            c_beat_reg;
    logic signed [ACC_W-1:0] c_mul_reg;
    logic signed [ACC_W-1:0] c_mul_next;
    logic                    c_sat_reg;
    logic                    c_sat_next;
    logic [SUM_W-1:0]        lo_round;
    logic [SUM_W-1:0]        mag;

    // stage D: coefficient add
    logic                     d_valid_reg;
    horner_beat_t             d_beat_reg;
    horner_beat_t             d_beat_next;
    logic signed [SUMD_W-1:0] sum;
    logic                     sum_ovf;
    logic signed [ACC_W-1:0]  sum_clamped;

    always_comb
    begin
        a_mag_next = in_beat.acc[ACC_W-1] ? (~in_beat.acc + ACC_W'(1)) : in_beat.acc;
        a_neg_next = in_beat.acc[ACC_W-1] ^ in_beat.x_neg;
    end

    always_comb
    begin
        b_hi_next = PROD_HI_W'(a_mag_reg[ACC_W-1:SPLIT]) * PROD_HI_W'(a_beat_reg.x_mag);
        b_lo_next = PROD_LO_W'(a_mag_reg[SPLIT-1:0]) * PROD_LO_W'(a_beat_reg.x_mag);
    end

    always_comb
    begin
        lo_round   = SUM_W'(b_lo_reg) + ROUND_HALF;
        mag        = SUM_W'({b_hi_reg, {PROD_SHIFT{1'b0}}})
                   + SUM_W'(lo_round[SUM_W-1:PROD_SHIFT]);
        c_sat_next = 1'b0;
        if (!b_neg_reg)
        begin
            if (mag > POS_LIMIT)
            begin
                c_mul_next = ACC_MAX;
                c_sat_next = 1'b1;
            end
            else
            begin
                c_mul_next = $signed(mag[ACC_W-1:0]);
            end
        end
        else
        begin
            if (mag > NEG_LIMIT)
            begin
                c_mul_next = ACC_MIN;
                c_sat_next = 1'b1;
            end
            else
            begin
                c_mul_next = -$signed(mag[ACC_W-1:0]);
            end
        end
    end

    always_comb
    begin
        sum         = SUMD_W'(c_mul_reg) + SUMD_W'(coef);
        sum_ovf     = sum[ACC_W] ^ sum[ACC_W-1];
        sum_clamped = sum_ovf ? (sum[ACC_W] ? ACC_MIN : ACC_MAX) : sum[ACC_W-1:0];
        d_beat_next = c_beat_reg;
        if (active)
        begin
            d_beat_next.acc = sum_clamped;
            d_beat_next.sat = c_beat_reg.sat | c_sat_reg | sum_ovf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_beat_reg <= in_beat;
            a_mag_reg  <= a_mag_next;
            a_neg_reg  <= a_neg_next;
            b_beat_reg <= a_beat_reg;
            b_neg_reg  <= a_neg_reg;
            b_hi_reg   <= b_hi_next;
            b_lo_reg   <= b_lo_next;
            c_beat_reg <= b_beat_reg;
            c_mul_reg  <= c_mul_next;
            c_sat_reg  <= c_sat_next;
            d_beat_reg <= d_beat_next;
        end
    end

    assign out_valid = d_valid_reg;
    assign out_beat  = d_beat_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/ppc_final_round.sv -----
// Final rounding of the accumulator to Q16.16 with saturation, two stages.
`default_nettype none

module ppc_final_round
    import ppc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic         in_valid,
    input  horner_beat_t in_beat,
    output logic         out_valid,
    output result_beat_t out_beat
);

    localparam int RND_W = ACC_W + 1;
    localparam int R_W   = RND_W - OUT_SHIFT;

    localparam logic [RND_W-1:0] ROUND_HALF = RND_W'(1) << (OUT_SHIFT - 1);
    localparam logic [R_W-1:0]   POS_LIMIT  = (R_W'(1) << (PIX_W - 1)) - R_W'(1);
    localparam logic [R_W-1:0]   NEG_LIMIT  = R_W'(1) << (PIX_W - 1);

    logic             f_valid_reg;
    logic [ACC_W-1:0] f_mag_reg;
    logic [ACC_W-1:0] f_mag_next;
    logic             f_neg_reg;
    logic             f_sat_reg;
    logic             f_last_reg;

    logic             o_valid_reg;
    result_beat_t     o_beat_reg;
    result_beat_t     o_beat_next;
    logic [RND_W-1:0] rnd;
    logic [R_W-1:0]   r;

    assign f_mag_next = in_beat.acc[ACC_W-1] ? (~in_beat.acc + ACC_W'(1)) : in_beat.acc;

    always_comb
    begin
        rnd              = RND_W'(f_mag_reg) + ROUND_HALF;
        r                = rnd[RND_W-1:OUT_SHIFT];
        o_beat_next.last = f_last_reg;
        o_beat_next.sat  = f_sat_reg;
        if (!f_neg_reg)
        begin
            if (r > POS_LIMIT)
            begin
                o_beat_next.pixel = $signed(POS_LIMIT[PIX_W-1:0]);
                o_beat_next.sat   = 1'b1;
            end
            else
            begin
                o_beat_next.pixel = $signed(r[PIX_W-1:0]);
            end
        end
        else
        begin
            if (r > NEG_LIMIT)
            begin
                o_beat_next.pixel = $signed(NEG_LIMIT[PIX_W-1:0]);
                o_beat_next.sat   = 1'b1;
            end
            else
            begin
                o_beat_next.pixel = -$signed(r[PIX_W-1:0]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            f_valid_reg <= in_valid;
            o_valid_reg <= f_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_mag_reg  <= f_mag_next;
            f_neg_reg  <= in_beat.acc[ACC_W-1];
            f_sat_reg  <= in_beat.sat;
            f_last_reg <= in_beat.last;
            o_beat_reg <= o_beat_next;
        end
    end

    assign out_valid = o_valid_reg;
    assign out_beat  = o_beat_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/ppc_out_skid.sv -----
// Output register with a skid slot; freezes the pipeline only when the skid slot is full.
`default_nettype none

module ppc_out_skid
    import ppc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  result_beat_t in_beat,
    output logic         en,
    output logic         out_valid,
    input  logic         out_stall,
    output result_beat_t out_beat
);

    logic         o_valid_reg;
    result_beat_t o_beat_reg;
    logic         s_valid_reg;
    result_beat_t s_beat_reg;
    logic         out_take;

    assign out_take = o_valid_reg & ~out_stall;
    assign en       = ~s_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
        end
        else if (s_valid_reg)
        begin
            // drain the skid slot first; the pipeline is frozen meanwhile
            if (out_take)
            begin
                s_valid_reg <= 1'b0;
            end
        end
        else if (!o_valid_reg || out_take)
        begin
            o_valid_reg <= in_valid;
        end
        else if (in_valid)
        begin
            s_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_valid_reg)
        begin
            if (out_take)
            begin
                o_beat_reg <= s_beat_reg;
            end
        end
        else if (!o_valid_reg || out_take)
        begin
            o_beat_reg <= in_beat;
        end
        else
        begin
            s_beat_reg <= in_beat;
        end
    end

    assign out_valid = o_valid_reg;
    assign out_beat  = o_beat_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/pixel_polynomial_correction_top.sv -----
// Pixel polynomial correction top: registers, entry stage, step chain, rounding, skid.
//
// Use: pixels stream in on the pix channel (pix_valid / pix_stall, payload pixel_in and
// last_pixel) and leave on the res channel (res_valid / res_stall, payload pixel_out,
// saturated and last_pixel_out). A beat moves when valid is high and stall is low.
// Each pixel yields exactly one result beat, in order.
// Throughput: one pixel per cycle, sustained, while the receiver takes results.
// Pipeline: an accepted input beat passes one entry stage, four stages per Horner step
// (magnitude, partial products, round and clip, coefficient add), two rounding stages and
// the output register. The latency does not depend on the degree in use.
// Stall: the whole pipeline moves on one enable. When res_stall holds a result, one
// more result lands in a skid slot; only then does pix_stall rise and the pipeline
// freeze. pix_stall is a register output with no path from res_stall.
// Reset: clears all valid bits, sets the degree to 1 and the coefficients to c1 = 1.0,
// all others 0 (identity mapping). Configuration writes (cfg_write, cfg_index,
// cfg_data) take effect at once and are meant for an idle block.
`default_nettype none

module pixel_polynomial_correction_top
    import ppc_pkg::*;
#(
    parameter int MAX_DEGREE = MAX_DEGREE_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     cfg_write,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]         cfg_data,

    input  logic                     pix_valid,
    output logic                     pix_stall,
    input  logic signed [PIX_W-1:0]  pixel_in,
    input  logic                     last_pixel,

    output logic                     res_valid,
    input  logic                     res_stall,
    output logic signed [PIX_W-1:0]  pixel_out,
    output logic                     saturated,
    output logic                     last_pixel_out
);

    localparam logic [DEG_W-1:0] DEG_LIMIT = DEG_W'(MAX_DEGREE);

    // configuration
    logic [DEG_W-1:0] degree_reg;
    coef_bank_t       bank_reg;
    logic [DEG_W-1:0] deg_eff;

    // pipeline control
    logic             en;

    // entry stage
    logic             e_valid_reg;
    horner_beat_t     e_beat_reg;
    horner_beat_t     e_beat_next;

    // step chain, element 0 is the entry stage
    logic [MAX_DEGREE:0] chain_valid;
    horner_beat_t        chain_beat [MAX_DEGREE+1];

    logic             fin_valid;
    result_beat_t     fin_beat;
    result_beat_t     res_beat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_reg  <= DEGREE_RESET;
            bank_reg[0] <= PAIR01_RESET;
            bank_reg[1] <= '0;
            bank_reg[2] <= '0;
            bank_reg[3] <= '0;
            bank_reg[4] <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_DEGREE:   degree_reg  <= cfg_data[DEG_W-1:0];
                REG_PAIR_0_1: bank_reg[0] <= cfg_data;
                REG_PAIR_2_3: bank_reg[1] <= cfg_data;
                REG_PAIR_4_5: bank_reg[2] <= cfg_data;
                REG_PAIR_6_7: bank_reg[3] <= cfg_data;
                REG_PAIR_8_9: bank_reg[4] <= cfg_data;
                default:      ; // drop writes to unknown indexes
            endcase
        end
    end

    // Degree zero runs as degree one; anything above the maximum runs at the maximum.
    always_comb
    begin
        if (degree_reg == '0)
        begin
            deg_eff = DEG_W'(1);
        end
        else if (degree_reg > DEG_LIMIT)
        begin
            deg_eff = DEG_LIMIT;
        end
        else
        begin
            deg_eff = degree_reg;
        end
    end

    // Entry: seed the accumulator with the top coefficient (Q8.24 sign-extends into
    // the Q24.24 accumulator) and split the sample into sign and magnitude once.
    always_comb
    begin
        e_beat_next.acc   = ACC_W'(coef_at(bank_reg, deg_eff));
        e_beat_next.x_neg = pixel_in[PIX_W-1];
        e_beat_next.x_mag = pixel_in[PIX_W-1] ? PIX_W'(-pixel_in) : PIX_W'(pixel_in);
        e_beat_next.sat   = 1'b0;
        e_beat_next.last  = last_pixel;
    end

    assign pix_stall = ~en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            e_valid_reg <= pix_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_beat_reg <= e_beat_next;
        end
    end

    assign chain_valid[0] = e_valid_reg;
    assign chain_beat[0]  = e_beat_reg;

    // Step units run from coefficient index MAX_DEGREE-1 down to zero; a unit whose
    // index is at or above the degree in use passes its beat through unchanged.
    for (genvar gi = 0; gi < MAX_DEGREE; gi++)
    begin : g_step
        localparam logic [DEG_W-1:0] K = DEG_W'(MAX_DEGREE - 1 - gi);

        ppc_horner_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .active    (K < deg_eff),
            .coef      (coef_at(bank_reg, K)),
            .in_valid  (chain_valid[gi]),
            .in_beat   (chain_beat[gi]),
            .out_valid (chain_valid[gi+1]),
            .out_beat  (chain_beat[gi+1])
        );
    end

    ppc_final_round u_final (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (chain_valid[MAX_DEGREE]),
        .in_beat   (chain_beat[MAX_DEGREE]),
        .out_valid (fin_valid),
        .out_beat  (fin_beat)
    );

    ppc_out_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fin_valid),
        .in_beat   (fin_beat),
        .en        (en),
        .out_valid (res_valid),
        .out_stall (res_stall),
        .out_beat  (res_beat)
    );

    assign pixel_out      = res_beat.pixel;
    assign saturated      = res_beat.sat;
    assign last_pixel_out = res_beat.last;

endmodule

`default_nettype wire
